/* rtl/gsa_pkg.sv */
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Shared types, codes and default sizes for the slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int SlotCountDefault = 16;
  localparam int GenBitsDefault   = 16;

  localparam int KindW    = 2;
  localparam int IndexW   = 4;
  localparam int HandleGW = 16;
  localparam int StatusW  = 2;
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_VALIDATE = 2'd1,
    KIND_FREE     = 2'd2,
    KIND_RSVD     = 2'd3
  } gsa_kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_STALE = 2'd2
  } gsa_status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } gsa_state_e;

  typedef struct packed {
    logic set;
    logic clr;
  } gsa_map_cmd_t;

endpackage

/* rtl/gsa_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module gsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gsa_free_map.sv */
// ----------------------------------------------------------------------------
// Slot occupancy map
// Holds one occupied bit per slot and finds the lowest free slot.
// ----------------------------------------------------------------------------
module gsa_free_map
  import gsa_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDefault,
  localparam int AW = $clog2(SLOT_COUNT)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gsa_map_cmd_t cmd_i,
  input  logic [AW-1:0] addr_i,
  output logic [AW-1:0] free_idx_o,
  output logic         full_o
);

  logic [SLOT_COUNT-1:0] occ_q;
  logic [SLOT_COUNT-1:0] occ_d;

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.set) begin
      occ_d[addr_i] = 1'b1;
    end
    if (cmd_i.clr) begin
      occ_d[addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_comb begin
    free_idx_o = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!occ_q[i]) begin
        free_idx_o = AW'(i);
      end
    end
  end

  assign full_o = &occ_q;

endmodule

/* rtl/generational_slot_allocator.sv */
// ----------------------------------------------------------------------------
// Generational slot allocator
// A pool of slots, each with an occupied bit and a wrapping generation
// counter, serving allocate, validate and free requests.
// ----------------------------------------------------------------------------
//  Channel   Direction  tuser               tdata
//  s_axis    in         kind                handle_index, handle_generation
//  m_axis    out        status              slot_index, slot_generation
//
//  The generation RAM is read in the cycle the item is accepted and, for a
//  free, written back in the cycle after.
//  After reset the generation RAM is cleared, one slot per cycle, and no item
//  is accepted until every slot has been cleared.
//  The result waits in an output register; a new item is accepted in ST_IDLE
//  while that register is empty or its result is taken in the same cycle.
// ----------------------------------------------------------------------------
module generational_slot_allocator
  import gsa_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDefault,
  parameter int GEN_BITS   = GenBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [3:0] handle_index, [19:4] handle_generation, [23:20] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [KindW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] slot_index, [19:4] slot_generation, [23:20] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [StatusW-1:0]  m_axis_tuser
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam logic [31:0] SlotCountW = 32'(SLOT_COUNT);
  localparam logic [AW-1:0] LastSlot = AW'(SLOT_COUNT - 1);

  gsa_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;

  gsa_kind_e           kind_q;
  logic [IndexW-1:0]   idx_q;
  logic [HandleGW-1:0] hgen_q;
  logic [AW-1:0]       addr_q;
  logic                in_pool_q;
  logic                full_q;

  logic                out_valid_q, out_valid_d;
  gsa_status_e         out_status_q, out_status_d;
  logic [IndexW-1:0]   out_index_q, out_index_d;
  logic [HandleGW-1:0] out_gen_q, out_gen_d;

  logic                in_accept;
  gsa_kind_e           in_kind;
  logic [IndexW-1:0]   in_idx;
  logic [31:0]         in_idx_ext;
  logic                in_pool;
  logic [AW-1:0]       rd_addr;

  logic [AW-1:0]       free_idx;
  logic                map_full;
  gsa_map_cmd_t        map_cmd;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [GEN_BITS-1:0] ram_wdata;
  logic [GEN_BITS-1:0] rd_gen;
  logic [GEN_BITS-1:0] gen_inc;
  logic [31:0]         rd_gen_ext;
  logic [31:0]         inc_ext;
  logic [31:0]         addr_ext;

  assign in_kind    = gsa_kind_e'(s_axis_tuser);
  assign in_idx     = s_axis_tdata[IndexW-1:0];
  assign in_idx_ext = 32'(in_idx);
  assign in_pool    = in_idx_ext < SlotCountW;
  assign rd_addr    = (in_kind == KIND_ALLOC) ? free_idx : in_idx_ext[AW-1:0];

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign gen_inc    = rd_gen + GEN_BITS'(1);
  assign rd_gen_ext = 32'(rd_gen);
  assign inc_ext    = 32'(gen_inc);
  assign addr_ext   = 32'(addr_q);

  gsa_free_map #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (map_cmd),
    .addr_i     (addr_q),
    .free_idx_o (free_idx),
    .full_o     (map_full)
  );

  gsa_ram #(
    .WIDTH(GEN_BITS),
    .DEPTH(SLOT_COUNT)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_gen)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    map_cmd      = '0;
    ram_we       = 1'b0;
    ram_waddr    = addr_q;
    ram_wdata    = gen_inc;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_gen_d    = out_gen_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d      = ST_IDLE;
        out_valid_d  = 1'b1;
        out_status_d = STATUS_OK;
        out_index_d  = idx_q;
        out_gen_d    = in_pool_q ? rd_gen_ext[HandleGW-1:0] : '0;
        case (kind_q)
          KIND_ALLOC: begin
            if (full_q) begin
              out_status_d = STATUS_FULL;
              out_index_d  = '0;
              out_gen_d    = '0;
            end else begin
              map_cmd.set = 1'b1;
              out_index_d = addr_ext[IndexW-1:0];
              out_gen_d   = rd_gen_ext[HandleGW-1:0];
            end
          end
          KIND_VALIDATE: begin
            if (!in_pool_q || (rd_gen_ext != 32'(hgen_q))) begin
              out_status_d = STATUS_STALE;
            end
          end
          KIND_FREE: begin
            if (in_pool_q) begin
              ram_we      = 1'b1;
              map_cmd.clr = 1'b1;
              out_gen_d   = inc_ext[HandleGW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q    <= in_kind;
      idx_q     <= in_idx;
      hgen_q    <= s_axis_tdata[IndexW +: HandleGW];
      addr_q    <= rd_addr;
      in_pool_q <= in_pool;
      full_q    <= map_full;
    end
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_gen_q    <= out_gen_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OutDataW - IndexW - HandleGW)'(0), out_gen_q, out_index_q};

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_EXEC)
    else $error("An accepted item did not move on to execution.");

  a_exec_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> !out_valid_q)
    else $error("The output register was busy during execution.");

  a_result_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("A result appeared without an item being executed.");

endmodule
